### rtl/v3au_pkg.sv
// v3au_pkg: shared types, constants and saturation helper for the vec3 arithmetic unit
// no dependencies; imported by every module under rtl
package v3au_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int WIDE_BITS = PROD_BITS + 4;
    localparam int ROOT_BITS = WORD_BITS;
    localparam int REM_BITS  = WORD_BITS + 2;
    localparam int STEPS     = WORD_BITS;
    localparam int LANES     = 3;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_NEG   = 3'd2,
        OP_SCALE = 3'd3,
        OP_NORM  = 3'd4,
        OP_CROSS = 3'd5,
        OP_DOT   = 3'd6,
        OP_MAG   = 3'd7
    } op_t;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [WIDE_BITS-1:0] wide_t;

    typedef struct packed {
        word_t r_x;
        word_t r_y;
        word_t r_z;
        word_t sc;
        logic  ov;
    } res_t;

    typedef struct packed {
        op_t              op;
        logic [LANES-1:0] neg;
        res_t             res;
    } side_t;

    // one component of the divide: partial remainder and dividend/quotient shifter
    typedef struct packed {
        logic [WORD_BITS-1:0] rem;
        logic [WORD_BITS-1:0] dq;
    } lane_t;

    typedef lane_t [LANES-1:0] lanes_t;

    typedef struct packed {
        word_t val;
        logic  ov;
    } sat_t;

    function automatic sat_t sat_word(input wide_t x);
        sat_t s;
        logic [WIDE_BITS-WORD_BITS:0] top;
        top   = x[WIDE_BITS-1:WORD_BITS-1];
        s.ov  = !(&top) && (|top);
        s.val = x[WORD_BITS-1:0];
        if (s.ov)
        begin
            s.val = x[WIDE_BITS-1] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                   : {1'b0, {(WORD_BITS-1){1'b1}}};
        end
        return s;
    endfunction

endpackage

### rtl/vec3_arith_unit.sv
// vec3_arith_unit: Q16.16 3-vector unit (add, sub, negate, scale, normalize, cross, dot, magnitude)
// pipeline stages: 3 front stages, 32 root cells, 32 divide cells, out reg
// throughput: one request per cycle; every request walks the full cell chain
// the chain stalls only while the two-entry result buffer is full
// reset: rst_n asynchronous active low clears all valid bits and empties the result buffer
// depends on v3au_pkg, v3au_front, v3au_sqrt_cell, v3au_div_cell
module vec3_arith_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  logic [2:0]      opcode,
    input  v3au_pkg::word_t u_x,
    input  v3au_pkg::word_t u_y,
    input  v3au_pkg::word_t u_z,
    input  v3au_pkg::word_t v_x,
    input  v3au_pkg::word_t v_y,
    input  v3au_pkg::word_t v_z,
    input  v3au_pkg::word_t scalar_in,
    output logic            res_valid,
    input  logic            res_ready,
    output v3au_pkg::word_t r_x,
    output v3au_pkg::word_t r_y,
    output v3au_pkg::word_t r_z,
    output v3au_pkg::word_t scalar_out,
    output logic            overflow
);
    import v3au_pkg::*;

    // whole chain moves together; held only when the result buffer is full
    logic adv;

    // root chain taps: index 0 is the front output, index STEPS the finished root
    logic                 sq_valid [STEPS+1];
    side_t                sq_side  [STEPS+1];
    lanes_t               sq_lanes [STEPS+1];
    logic [PROD_BITS-1:0] sq_n     [STEPS+1];
    logic [REM_BITS-1:0]  sq_rem   [STEPS+1];
    logic [ROOT_BITS-1:0] sq_root  [STEPS+1];

    // divide chain taps: index 0 takes the finished root as divisor
    logic                 dv_valid [STEPS+1];
    side_t                dv_side  [STEPS+1];
    lanes_t               dv_lanes [STEPS+1];
    logic [ROOT_BITS-1:0] dv_root  [STEPS+1];

    // result buffer: head register plus skid entry
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    res_t       head_reg;
    res_t       head_next;
    res_t       skid_reg;
    res_t       skid_next;
    res_t       fin;
    logic       push;
    logic       pop;

    assign adv       = (cnt_reg != 2'd2);
    assign req_ready = adv;

    v3au_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (req_valid),
        .opcode    (opcode),
        .u_x       (u_x),
        .u_y       (u_y),
        .u_z       (u_z),
        .v_x       (v_x),
        .v_y       (v_y),
        .v_z       (v_z),
        .scalar_in (scalar_in),
        .out_valid (sq_valid[0]),
        .out_side  (sq_side[0]),
        .out_sq    (sq_n[0]),
        .out_lanes (sq_lanes[0])
    );

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    // one root bit per cell, most significant first
    for (genvar k = 0; k < STEPS; k++)
    begin : g_sqrt
        v3au_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (sq_valid[k]),
            .in_side   (sq_side[k]),
            .in_lanes  (sq_lanes[k]),
            .in_n      (sq_n[k]),
            .in_rem    (sq_rem[k]),
            .in_root   (sq_root[k]),
            .out_valid (sq_valid[k+1]),
            .out_side  (sq_side[k+1]),
            .out_lanes (sq_lanes[k+1]),
            .out_n     (sq_n[k+1]),
            .out_rem   (sq_rem[k+1]),
            .out_root  (sq_root[k+1])
        );
    end

    assign dv_valid[0] = sq_valid[STEPS];
    assign dv_side[0]  = sq_side[STEPS];
    assign dv_lanes[0] = sq_lanes[STEPS];
    assign dv_root[0]  = sq_root[STEPS];

    // one quotient bit per cell; |u*s| / root stays below 2^32
    for (genvar k = 0; k < STEPS; k++)
    begin : g_div
        v3au_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (dv_valid[k]),
            .in_side   (dv_side[k]),
            .in_lanes  (dv_lanes[k]),
            .in_root   (dv_root[k]),
            .out_valid (dv_valid[k+1]),
            .out_side  (dv_side[k+1]),
            .out_lanes (dv_lanes[k+1]),
            .out_root  (dv_root[k+1])
        );
    end

    // final selection: normalize and magnitude come from the chain, the rest rides along
    always_comb
    begin
        sat_t  s [LANES];
        wide_t q;
        fin = dv_side[STEPS].res;
        for (int i = 0; i < LANES; i++)
        begin
            q = WIDE_BITS'({1'b0, dv_lanes[STEPS][i].dq});
            if (dv_side[STEPS].neg[i])
            begin
                q = -q;
            end
            s[i] = sat_word(q);
        end
        case (dv_side[STEPS].op) inside
            OP_NORM:
            begin
                fin = '0;
                // zero vector passes through, which is all zeros
                if (dv_root[STEPS] != '0)
                begin
                    fin.r_x = s[0].val;
                    fin.r_y = s[1].val;
                    fin.r_z = s[2].val;
                    fin.ov  = s[0].ov | s[1].ov | s[2].ov;
                end
            end
            OP_MAG:
            begin
                s[0]   = sat_word(WIDE_BITS'({1'b0, dv_root[STEPS]}));
                fin    = '0;
                fin.sc = s[0].val;
                fin.ov = s[0].ov;
            end
            OP_ADD, OP_SUB, OP_NEG, OP_SCALE, OP_CROSS, OP_DOT:
            begin
            end
        endcase
    end

    assign push = dv_valid[STEPS] && adv;
    assign pop  = res_valid && res_ready;

    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        skid_next = skid_reg;
        case (cnt_reg)
            2'd0:
            begin
                if (push)
                begin
                    head_next = fin;
                    cnt_next  = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    head_next = fin;
                end
                else if (push)
                begin
                    skid_next = fin;
                    cnt_next  = 2'd2;
                end
                else if (pop)
                begin
                    cnt_next = 2'd0;
                end
            end
            default:
            begin
                if (pop)
                begin
                    head_next = skid_reg;
                    cnt_next  = 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign res_valid  = (cnt_reg != 2'd0);
    assign r_x        = head_reg.r_x;
    assign r_y        = head_reg.r_y;
    assign r_z        = head_reg.r_z;
    assign scalar_out = head_reg.sc;
    assign overflow   = head_reg.ov;

    // buffer never holds more than two results
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    // normalize of a zero vector never reports overflow
    a_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid[STEPS] && dv_side[STEPS].op == OP_NORM && dv_root[STEPS] == '0)
        |-> (!fin.ov && fin.r_x == '0 && fin.r_y == '0 && fin.r_z == '0))
        else $error("zero vector normalize result not zero");

    // magnitude is never negative
    a_mag_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid[STEPS] && dv_side[STEPS].op == OP_MAG) |-> !fin.sc[WORD_BITS-1])
        else $error("negative magnitude");

endmodule

### rtl/v3au_front.sv
// v3au_front: request register, product stage and sum/saturate stage
// depends on v3au_pkg
module v3au_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [2:0]         opcode,
    input  v3au_pkg::word_t    u_x,
    input  v3au_pkg::word_t    u_y,
    input  v3au_pkg::word_t    u_z,
    input  v3au_pkg::word_t    v_x,
    input  v3au_pkg::word_t    v_y,
    input  v3au_pkg::word_t    v_z,
    input  v3au_pkg::word_t    scalar_in,
    output logic               out_valid,
    output v3au_pkg::side_t    out_side,
    output logic [v3au_pkg::PROD_BITS-1:0] out_sq,
    output v3au_pkg::lanes_t   out_lanes
);
    import v3au_pkg::*;

    // stage 1: request register
    logic  s1_valid_reg;
    op_t   s1_op_reg;
    word_t s1_u_reg [LANES];
    word_t s1_v_reg [LANES];
    word_t s1_s_reg;

    // stage 2: products and add/sub/negate
    logic  s2_valid_reg;
    op_t   s2_op_reg;
    logic signed [PROD_BITS-1:0] s2_p_reg [2*LANES];
    logic signed [PROD_BITS-1:0] s2_p_next [2*LANES];
    word_t s2_ar_reg [LANES];
    word_t s2_ar_next [LANES];
    logic  s2_ov_reg;
    logic  s2_ov_next;
    word_t mul_a [2*LANES];
    word_t mul_b [2*LANES];

    // stage 3
    logic   s3_valid_reg;
    side_t  s3_side_reg;
    side_t  s3_side_next;
    logic [PROD_BITS-1:0] s3_sq_reg;
    logic [PROD_BITS-1:0] s3_sq_next;
    lanes_t s3_lanes_reg;
    lanes_t s3_lanes_next;

    // operand selection for the six shared multipliers
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            mul_a[i]         = s1_u_reg[i];
            mul_b[i]         = s1_s_reg;
            mul_a[i + LANES] = s1_u_reg[i];
            mul_b[i + LANES] = s1_u_reg[i];
        end
        case (s1_op_reg)
            OP_CROSS:
            begin
                mul_a[0] = s1_u_reg[1]; mul_b[0] = s1_v_reg[2];
                mul_a[1] = s1_u_reg[2]; mul_b[1] = s1_v_reg[0];
                mul_a[2] = s1_u_reg[0]; mul_b[2] = s1_v_reg[1];
                mul_a[3] = s1_u_reg[2]; mul_b[3] = s1_v_reg[1];
                mul_a[4] = s1_u_reg[0]; mul_b[4] = s1_v_reg[2];
                mul_a[5] = s1_u_reg[1]; mul_b[5] = s1_v_reg[0];
            end
            OP_DOT:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    mul_a[i] = s1_u_reg[i];
                    mul_b[i] = s1_v_reg[i];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        sat_t  s;
        wide_t w;
        s2_ov_next = 1'b0;
        for (int i = 0; i < 2*LANES; i++)
        begin
            s2_p_next[i] = mul_a[i] * mul_b[i];
        end
        for (int i = 0; i < LANES; i++)
        begin
            case (s1_op_reg)
                OP_SUB:  w = WIDE_BITS'(s1_u_reg[i]) - WIDE_BITS'(s1_v_reg[i]);
                OP_NEG:  w = -WIDE_BITS'(s1_u_reg[i]);
                default: w = WIDE_BITS'(s1_u_reg[i]) + WIDE_BITS'(s1_v_reg[i]);
            endcase
            s = sat_word(w);
            s2_ar_next[i] = s.val;
            s2_ov_next    = s2_ov_next | s.ov;
        end
    end

    // stage 3: fold products to Q format, sum of squares, divide operands
    always_comb
    begin
        sat_t  s [LANES];
        wide_t w [LANES];
        logic [PROD_BITS-1:0] mag;
        for (int i = 0; i < LANES; i++)
        begin
            w[i] = '0;
        end
        s3_side_next     = '0;
        s3_side_next.op  = s2_op_reg;
        case (s2_op_reg) inside
            OP_SCALE:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    w[i] = WIDE_BITS'(s2_p_reg[i]) >>> FRAC_BITS;
                end
            end
            OP_CROSS:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    w[i] = (WIDE_BITS'(s2_p_reg[i]) - WIDE_BITS'(s2_p_reg[i + LANES]))
                           >>> FRAC_BITS;
                end
            end
            OP_DOT:
            begin
                w[0] = (WIDE_BITS'(s2_p_reg[0]) + WIDE_BITS'(s2_p_reg[1])
                       + WIDE_BITS'(s2_p_reg[2])) >>> FRAC_BITS;
            end
            OP_ADD, OP_SUB, OP_NEG, OP_NORM, OP_MAG:
            begin
            end
        endcase
        for (int i = 0; i < LANES; i++)
        begin
            s[i] = sat_word(w[i]);
        end
        case (s2_op_reg) inside
            OP_ADD, OP_SUB, OP_NEG:
            begin
                s3_side_next.res.r_x = s2_ar_reg[0];
                s3_side_next.res.r_y = s2_ar_reg[1];
                s3_side_next.res.r_z = s2_ar_reg[2];
                s3_side_next.res.ov  = s2_ov_reg;
            end
            OP_SCALE, OP_CROSS:
            begin
                s3_side_next.res.r_x = s[0].val;
                s3_side_next.res.r_y = s[1].val;
                s3_side_next.res.r_z = s[2].val;
                s3_side_next.res.ov  = s[0].ov | s[1].ov | s[2].ov;
            end
            OP_DOT:
            begin
                s3_side_next.res.sc = s[0].val;
                s3_side_next.res.ov = s[0].ov;
            end
            OP_NORM, OP_MAG:
            begin
            end
        endcase

        // squares are non-negative and their sum fits 64 bits
        s3_sq_next = PROD_BITS'(unsigned'(s2_p_reg[3])) + PROD_BITS'(unsigned'(s2_p_reg[4]))
                   + PROD_BITS'(unsigned'(s2_p_reg[5]));
        for (int i = 0; i < LANES; i++)
        begin
            s3_side_next.neg[i] = s2_p_reg[i][PROD_BITS-1];
            mag = s2_p_reg[i][PROD_BITS-1] ? unsigned'(-s2_p_reg[i]) : unsigned'(s2_p_reg[i]);
            s3_lanes_next[i].rem = mag[PROD_BITS-1:WORD_BITS];
            s3_lanes_next[i].dq  = mag[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg    <= op_t'(opcode);
            s1_u_reg[0]  <= u_x;
            s1_u_reg[1]  <= u_y;
            s1_u_reg[2]  <= u_z;
            s1_v_reg[0]  <= v_x;
            s1_v_reg[1]  <= v_y;
            s1_v_reg[2]  <= v_z;
            s1_s_reg     <= scalar_in;
            s2_op_reg    <= s1_op_reg;
            s2_p_reg     <= s2_p_next;
            s2_ar_reg    <= s2_ar_next;
            s2_ov_reg    <= s2_ov_next;
            s3_side_reg  <= s3_side_next;
            s3_sq_reg    <= s3_sq_next;
            s3_lanes_reg <= s3_lanes_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_side  = s3_side_reg;
    assign out_sq    = s3_sq_reg;
    assign out_lanes = s3_lanes_reg;

endmodule

### rtl/v3au_sqrt_cell.sv
// v3au_sqrt_cell: one root bit of the digit-by-digit square root
// depends on v3au_pkg
module v3au_sqrt_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_valid,
    input  v3au_pkg::side_t                in_side,
    input  v3au_pkg::lanes_t               in_lanes,
    input  logic [v3au_pkg::PROD_BITS-1:0] in_n,
    input  logic [v3au_pkg::REM_BITS-1:0]  in_rem,
    input  logic [v3au_pkg::ROOT_BITS-1:0] in_root,
    output logic                           out_valid,
    output v3au_pkg::side_t                out_side,
    output v3au_pkg::lanes_t               out_lanes,
    output logic [v3au_pkg::PROD_BITS-1:0] out_n,
    output logic [v3au_pkg::REM_BITS-1:0]  out_rem,
    output logic [v3au_pkg::ROOT_BITS-1:0] out_root
);
    import v3au_pkg::*;

    logic                 valid_reg;
    side_t                side_reg;
    lanes_t               lanes_reg;
    logic [PROD_BITS-1:0] n_reg;
    logic [REM_BITS-1:0]  rem_reg;
    logic [REM_BITS-1:0]  rem_next;
    logic [ROOT_BITS-1:0] root_reg;
    logic [ROOT_BITS-1:0] root_next;
    logic [REM_BITS+1:0]  rem_sh;
    logic [REM_BITS+1:0]  trial;

    // bring down two radicand bits, try root bit one
    always_comb
    begin
        rem_sh = {in_rem, in_n[PROD_BITS-1 -: 2]};
        trial  = (REM_BITS+2)'({in_root, 2'b01});
        if (rem_sh >= trial)
        begin
            rem_next  = REM_BITS'(rem_sh - trial);
            root_next = {in_root[ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_next  = REM_BITS'(rem_sh);
            root_next = {in_root[ROOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg  <= in_side;
            lanes_reg <= in_lanes;
            n_reg     <= {in_n[PROD_BITS-3:0], 2'b00};
            rem_reg   <= rem_next;
            root_reg  <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_lanes = lanes_reg;
    assign out_n     = n_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

### rtl/v3au_div_cell.sv
// v3au_div_cell: one quotient bit of the restoring divide, for all three components
// depends on v3au_pkg
module v3au_div_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_valid,
    input  v3au_pkg::side_t                in_side,
    input  v3au_pkg::lanes_t               in_lanes,
    input  logic [v3au_pkg::ROOT_BITS-1:0] in_root,
    output logic                           out_valid,
    output v3au_pkg::side_t                out_side,
    output v3au_pkg::lanes_t               out_lanes,
    output logic [v3au_pkg::ROOT_BITS-1:0] out_root
);
    import v3au_pkg::*;

    logic                 valid_reg;
    side_t                side_reg;
    lanes_t               lanes_reg;
    lanes_t               lanes_next;
    logic [ROOT_BITS-1:0] root_reg;

    always_comb
    begin
        logic [WORD_BITS:0] t;
        for (int i = 0; i < LANES; i++)
        begin
            t = {in_lanes[i].rem, in_lanes[i].dq[WORD_BITS-1]};
            if (t >= {1'b0, in_root})
            begin
                lanes_next[i].rem = WORD_BITS'(t - {1'b0, in_root});
                lanes_next[i].dq  = {in_lanes[i].dq[WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                lanes_next[i].rem = t[WORD_BITS-1:0];
                lanes_next[i].dq  = {in_lanes[i].dq[WORD_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg  <= in_side;
            lanes_reg <= lanes_next;
            root_reg  <= in_root;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_lanes = lanes_reg;
    assign out_root  = root_reg;

endmodule
